@@ rtl/vlpi_pkg.sv @@
// ----------------------------------------------------------------------------
// vlpi_pkg
// Shared widths, register indexes and fixed-point constants for the
// vibration limiting pi controller.
// ----------------------------------------------------------------------------
package vlpi_pkg;

    // field widths
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned VIB_W   = 16;
    localparam int unsigned GAIN_W  = 12;
    localparam int unsigned INTEG_W = 28;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // q10 fraction bits
    localparam int unsigned FRAC_W = 10;

    // largest value the integrator can hold after a clamp (65535 * 1024)
    localparam logic [INTEG_W-1:0] INTEG_MAX = 28'd67107840;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIB_LIMIT = 3'd0,
        REG_GAIN_P    = 3'd1,
        REG_GAIN_I    = 3'd2,
        REG_FLOOR     = 3'd3,
        REG_CEILING   = 3'd4
    } t_reg_idx;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_INIT   = 1'b1;

endpackage

@@ rtl/vibration_limit_pi_controller.sv @@
// ----------------------------------------------------------------------------
// vibration_limit_pi_controller
// Q10 pi controller that lowers a motor speed command to hold vibration
// near a configured limit, with a clamped integrator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per accepted
//   edge. A sample item (req_type 0) gives exactly one speed command item on
//   the output channel (o_out_valid / i_out_stall); an init item (req_type 1)
//   reloads the integrator from initial_speed and gives no item.
//   An item is taken into the input register and worked on there; its
//   result is registered in the output register, from which the speed
//   command shows. Throughput is one item per cycle while the receiver
//   does not stall: the integrator update for one item closes between the
//   input and result registers, so the next item can follow at once.
//   When the receiver stalls, the finished result holds in the output
//   register and one further item waits in the input register; a waiting
//   init item still drains because it needs no output slot.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
//   user must write only while the block is idle, which it does not enforce;
//   writes to unused indexes are ignored. Reset (synchronous, active low)
//   empties both registers, clears the integrator, resets config registers.
// ----------------------------------------------------------------------------
module vibration_limit_pi_controller (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [vlpi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [vlpi_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_req_type,
    input  logic [vlpi_pkg::VIB_W-1:0]            i_vibration,
    input  logic [vlpi_pkg::SPEED_W-1:0]          i_target_speed,
    input  logic [vlpi_pkg::SPEED_W-1:0]          i_initial_speed,
    // output channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [vlpi_pkg::SPEED_W-1:0]          o_speed_cmd
);

    localparam int unsigned SW  = vlpi_pkg::SPEED_W;
    localparam int unsigned FW  = vlpi_pkg::FRAC_W;
    localparam int unsigned IW  = vlpi_pkg::INTEG_W;
    localparam int unsigned GW  = vlpi_pkg::GAIN_W;
    // error, products and sums
    localparam int unsigned EW  = vlpi_pkg::VIB_W + 1;
    localparam int unsigned PW  = 30;
    localparam int unsigned QW  = PW - FW;

    // configuration registers
    logic [vlpi_pkg::VIB_W-1:0] r_vib_limit;
    logic [GW-1:0]              r_gain_p;
    logic [GW-1:0]              r_gain_i;
    logic [SW-1:0]              r_floor;
    logic [SW-1:0]              r_ceiling;

    // input register
    logic                       r_in_valid;
    logic                       r_in_type;
    logic [vlpi_pkg::VIB_W-1:0] r_in_vib;
    logic [SW-1:0]              r_in_target;
    logic [SW-1:0]              r_in_start;

    // state and result register
    logic signed [IW-1:0]       r_integ;
    logic signed [IW-1:0]       n_integ;
    logic                       r_out_valid;
    logic [SW-1:0]              r_out_speed;
    logic [SW-1:0]              n_out_speed;

    logic                       w_advance;
    logic                       w_in_take;
    logic                       w_out_free;

    // datapath intermediates
    logic signed [EW-1:0]       w_err;
    logic signed [PW-1:0]       w_err_x;
    logic signed [PW-1:0]       w_prop;
    logic signed [PW-1:0]       w_iprod;
    logic signed [PW-1:0]       w_isum;
    logic signed [PW-1:0]       w_tgt_q;
    logic signed [PW-1:0]       w_flr_q;
    logic signed [PW-1:0]       w_integ_clamped;
    logic signed [PW-1:0]       w_total;
    logic signed [QW-1:0]       w_quot;
    logic signed [QW-1:0]       w_tgt_s;
    logic signed [QW-1:0]       w_flr_s;
    logic [SW-1:0]              w_start;

    // handshake: an init item leaves without needing the output slot
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && ((r_in_type == vlpi_pkg::REQ_INIT) || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_speed_cmd = r_out_speed;

    // error and the two gain products
    assign w_err   = $signed({1'b0, r_vib_limit}) - $signed({1'b0, r_in_vib});
    assign w_err_x = PW'(w_err);
    assign w_prop  = $signed(PW'(r_gain_p)) * w_err_x;
    assign w_iprod = $signed(PW'(r_gain_i)) * w_err_x;

    // integrator update with the target bound tested first
    assign w_isum  = PW'(r_integ) + w_iprod;
    assign w_tgt_q = $signed(PW'({r_in_target, {FW{1'b0}}}));
    assign w_flr_q = $signed(PW'({r_floor, {FW{1'b0}}}));

    always_comb begin
        if (w_isum > w_tgt_q) begin
            w_integ_clamped = w_tgt_q;
        end else if (w_isum < w_flr_q) begin
            w_integ_clamped = w_flr_q;
        end else begin
            w_integ_clamped = w_isum;
        end
    end

    // output: divide by 1024 rounding toward zero, then clamp
    assign w_total = w_prop + w_integ_clamped;
    assign w_tgt_s = $signed(QW'(r_in_target));
    assign w_flr_s = $signed(QW'(r_floor));

    always_comb begin
        w_quot = QW'(w_total >>> FW);
        if (w_total[PW-1] && (w_total[FW-1:0] != '0)) begin
            w_quot = w_quot + QW'(1);
        end
        if (w_quot > w_tgt_s) begin
            n_out_speed = r_in_target;
        end else if (w_quot < w_flr_s) begin
            n_out_speed = r_floor;
        end else begin
            n_out_speed = w_quot[SW-1:0];
        end
    end

    // init: clamp start speed to ceiling first, then floor
    always_comb begin
        if (r_in_start > r_ceiling) begin
            w_start = r_ceiling;
        end else if (r_in_start < r_floor) begin
            w_start = r_floor;
        end else begin
            w_start = r_in_start;
        end
    end

    always_comb begin
        if (r_in_type == vlpi_pkg::REQ_INIT) begin
            n_integ = $signed(IW'({w_start, {FW{1'b0}}}));
        end else begin
            n_integ = IW'(w_integ_clamped);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vib_limit <= '0;
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_floor     <= '0;
            r_ceiling   <= '1;
        end else if (i_cfg_we) begin
            case (vlpi_pkg::t_reg_idx'(i_cfg_idx))
                vlpi_pkg::REG_VIB_LIMIT: r_vib_limit <= i_cfg_data;
                vlpi_pkg::REG_GAIN_P:    r_gain_p    <= i_cfg_data[GW-1:0];
                vlpi_pkg::REG_GAIN_I:    r_gain_i    <= i_cfg_data[GW-1:0];
                vlpi_pkg::REG_FLOOR:     r_floor     <= i_cfg_data;
                vlpi_pkg::REG_CEILING:   r_ceiling   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_type   <= i_req_type;
            r_in_vib    <= i_vibration;
            r_in_target <= i_target_speed;
            r_in_start  <= i_initial_speed;
        end
    end

    // integrator and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_integ <= n_integ;
            end
            if (w_advance && (r_in_type == vlpi_pkg::REQ_SAMPLE)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_advance && (r_in_type == vlpi_pkg::REQ_SAMPLE)) begin
            r_out_speed <= n_out_speed;
        end
    end

    // integrator always stays within the clamp range
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ >= 0) && (r_integ <= $signed(vlpi_pkg::INTEG_MAX)))
        else $error("integrator left its clamp range");

    // a waiting sample is held while the result slot is blocked
    a_sample_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_type == vlpi_pkg::REQ_SAMPLE) && r_out_valid && i_out_stall)
        |-> o_in_stall)
        else $error("sample advanced into a full result register");

    // a sample that advances shows a result next cycle
    a_sample_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_type == vlpi_pkg::REQ_SAMPLE)) |=> o_out_valid)
        else $error("sample gave no result");

    // an init item never creates a result
    a_init_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_in_type == vlpi_pkg::REQ_INIT))
        |=> (o_out_valid == $past(r_out_valid && i_out_stall)))
        else $error("init item produced a result");

endmodule
